/* hdl/lkvc_pkg.sv */
// shared types and constants for the lru key-value cache
// no dependencies; used by lru_key_value_cache
`timescale 1ns / 1ps
`default_nettype none

package lkvc_pkg;

  localparam int KEY_W   = 32;
  localparam int VALUE_W = 32;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  typedef logic signed [KEY_W-1:0]   key_t;
  typedef logic signed [VALUE_W-1:0] value_t;

endpackage

`default_nettype wire

/* hdl/lru_key_value_cache.sv */
// lru key-value cache top level: fully associative store with lru replacement
// depends on lkvc_pkg
`timescale 1ns / 1ps
`default_nettype none

// A request (get or put) is taken into an input register, then resolved by a
// parallel key compare over all ENTRIES slots and a rank update; one request
// completes per cycle and a new one can be taken every cycle unless a get is
// held by a stalled output. A get produces one result transfer (found and
// read_value, value 0 on a miss); a put produces none. Recency ranks are kept
// per slot, 0 being the most recent. Capacity 0 acts as 1, above ENTRIES as
// ENTRIES. The user writes configuration only while idle; it is not enforced.
module lru_key_value_cache #(
  parameter int ENTRIES = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_we,
  input  wire  [lkvc_pkg::CAP_W-1:0]         cfg_wdata,
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire                                in_operation,
  input  wire  signed [lkvc_pkg::KEY_W-1:0]  in_lookup_key,
  input  wire  signed [lkvc_pkg::VALUE_W-1:0] in_store_value,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic                               out_found,
  output logic signed [lkvc_pkg::VALUE_W-1:0] out_read_value
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int CW = (UW > lkvc_pkg::CAP_W) ? UW : lkvc_pkg::CAP_W;
  localparam logic [CW-1:0] ENTRIES_C = CW'(ENTRIES);

  // configuration
  logic [lkvc_pkg::CAP_W-1:0] capacity_r;

  // input register
  logic             req_valid_r;
  lkvc_pkg::op_t    req_op_r;
  lkvc_pkg::key_t   req_key_r;
  lkvc_pkg::value_t req_value_r;

  // result register
  logic             out_valid_r;
  logic             out_found_r;
  lkvc_pkg::value_t out_value_r;

  // cache state
  lkvc_pkg::key_t   entry_key_r   [ENTRIES];
  lkvc_pkg::value_t entry_value_r [ENTRIES];
  logic [ENTRIES-1:0] entry_valid_r, entry_valid_nxt;
  logic [IW-1:0]    rank_r   [ENTRIES];
  logic [IW-1:0]    rank_nxt [ENTRIES];
  logic [UW-1:0]    used_r, used_nxt;

  logic               adv;
  logic               in_xfer;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] evict_sel;
  logic [ENTRIES-1:0] wr_key_sel;
  logic [ENTRIES-1:0] wr_value_sel;
  logic [ENTRIES-1:0] valid_after_evict;
  logic               hit;
  logic [IW-1:0]      hit_rank;
  lkvc_pkg::value_t   hit_value;
  logic [CW-1:0]      eff_cap;
  logic               do_evict;
  logic               slot_found;
  logic [IW-1:0]      slot_idx;
  logic [IW-1:0]      oldest_rank;

  assign adv      = req_valid_r &&
                    (req_op_r == lkvc_pkg::OP_PUT || !out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !adv;
  assign in_xfer  = in_valid && !in_stall;

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_read_value = out_value_r;

  // tag compare and hit read
  always_comb begin
    hit       = 1'b0;
    hit_rank  = '0;
    hit_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      match[i]  = entry_valid_r[i] && (entry_key_r[i] == req_key_r);
      hit       = hit | match[i];
      hit_rank  = hit_rank | (match[i] ? rank_r[i] : '0);
      hit_value = hit_value | (match[i] ? entry_value_r[i] : '0);
    end
  end

  // effective capacity and eviction choice
  always_comb begin
    eff_cap = CW'(capacity_r);
    if (capacity_r == '0) begin
      eff_cap = CW'(1);
    end else if (eff_cap > ENTRIES_C) begin
      eff_cap = ENTRIES_C;
    end
    do_evict    = (CW'(used_r) >= eff_cap);
    oldest_rank = IW'(used_r - UW'(1));
    for (int i = 0; i < ENTRIES; i++) begin
      evict_sel[i]         = do_evict && entry_valid_r[i] && (rank_r[i] == oldest_rank);
      valid_after_evict[i] = entry_valid_r[i] && !evict_sel[i];
    end
    slot_found = 1'b0;
    slot_idx   = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_after_evict[i]) begin
        slot_found = 1'b1;
        slot_idx   = IW'(i);
      end
    end
  end

  // state update
  always_comb begin
    entry_valid_nxt = entry_valid_r;
    used_nxt        = used_r;
    wr_key_sel      = '0;
    wr_value_sel    = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rank_nxt[i] = rank_r[i];
    end
    if (adv) begin
      if (hit) begin
        for (int i = 0; i < ENTRIES; i++) begin
          if (match[i]) begin
            rank_nxt[i] = '0;
          end else if (entry_valid_r[i] && rank_r[i] < hit_rank) begin
            rank_nxt[i] = rank_r[i] + IW'(1);
          end
        end
        if (req_op_r == lkvc_pkg::OP_PUT) begin
          wr_value_sel = match;
        end
      end else if (req_op_r == lkvc_pkg::OP_PUT) begin
        for (int i = 0; i < ENTRIES; i++) begin
          entry_valid_nxt[i] = valid_after_evict[i];
          if (evict_sel[i]) begin
            rank_nxt[i] = '0;
          end
        end
        if (slot_found) begin
          for (int i = 0; i < ENTRIES; i++) begin
            if (valid_after_evict[i]) begin
              rank_nxt[i] = rank_r[i] + IW'(1);
            end else if (IW'(i) == slot_idx) begin
              rank_nxt[i]        = '0;
              entry_valid_nxt[i] = 1'b1;
              wr_key_sel[i]      = 1'b1;
              wr_value_sel[i]    = 1'b1;
            end
          end
        end
        used_nxt = used_r - (do_evict ? UW'(1) : '0) + (slot_found ? UW'(1) : '0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r    <= lkvc_pkg::CAP_RESET;
      req_valid_r   <= 1'b0;
      out_valid_r   <= 1'b0;
      entry_valid_r <= '0;
      used_r        <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        capacity_r <= cfg_wdata;
      end
      if (in_xfer) begin
        req_valid_r <= 1'b1;
      end else if (adv) begin
        req_valid_r <= 1'b0;
      end
      if (adv && req_op_r == lkvc_pkg::OP_GET) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      entry_valid_r <= entry_valid_nxt;
      used_r        <= used_nxt;
      for (int i = 0; i < ENTRIES; i++) begin
        rank_r[i] <= rank_nxt[i];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_op_r    <= lkvc_pkg::op_t'(in_operation);
      req_key_r   <= in_lookup_key;
      req_value_r <= in_store_value;
    end
    if (adv && req_op_r == lkvc_pkg::OP_GET) begin
      out_found_r <= hit;
      out_value_r <= hit_value;
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (wr_key_sel[i]) begin
        entry_key_r[i] <= req_key_r;
      end
      if (wr_value_sel[i]) begin
        entry_value_r[i] <= req_value_r;
      end
    end
  end

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// self-checking testbench for lru_key_value_cache: a queue-fed driver, a monitor and
// an internal lru cache model that predicts every get result
// depends on lkvc_pkg and lru_key_value_cache
`timescale 1ns / 1ps

module tb_top;

  localparam int ENTRIES     = 16;
  localparam int N_PHASES    = 10;
  localparam int PHASE_ITEMS = 193;
  localparam int PRESS_PHASE = 4;
  localparam int HOLD_CYCLES = 200;
  localparam int SETTLE      = 10;
  localparam int QUIET_LIMIT = 3000;
  localparam int MAX_REPORTS = 10;
  localparam int CAP_PLAN [N_PHASES] = '{31, 1, 16, 2, 12, 3, 0, 8, 20, 5};

  typedef struct {
    lkvc_pkg::op_t    op;
    lkvc_pkg::key_t   key;
    lkvc_pkg::value_t val;
  } request_t;

  typedef struct {
    logic             found;
    lkvc_pkg::value_t val;
  } lookup_t;

  logic                       clk            = 1'b0;
  logic                       rst_n          = 1'b0;
  logic                       cfg_we         = 1'b0;
  logic [lkvc_pkg::CAP_W-1:0] cfg_wdata      = '0;
  logic                       in_valid       = 1'b0;
  logic                       in_stall;
  logic                       in_operation   = 1'b0;
  lkvc_pkg::key_t             in_lookup_key  = '0;
  lkvc_pkg::value_t           in_store_value = '0;
  logic                       out_valid;
  logic                       out_stall      = 1'b0;
  logic                       out_found;
  lkvc_pkg::value_t           out_read_value;

  // cache model state
  lkvc_pkg::key_t   slot_key  [ENTRIES];
  lkvc_pkg::value_t slot_val  [ENTRIES];
  bit               slot_live [ENTRIES];
  int unsigned      slot_age  [ENTRIES];
  int unsigned      live_count  = 0;
  int unsigned      cap_setting = lkvc_pkg::CAP_RESET;

  request_t    req_q[$];
  lookup_t     lookups_due[$];
  request_t    on_bus;
  int unsigned n_queued   = 0;
  int unsigned n_taken    = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned n_bad      = 0;
  int unsigned quiet      = 0;
  int          phase_no   = -1;
  bit          send_calm  = 1'b0;
  bit          recv_calm  = 1'b0;
  bit          held       = 1'b0;

  lru_key_value_cache #(.ENTRIES(ENTRIES)) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_lookup_key (in_lookup_key),
    .in_store_value(in_store_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_found     (out_found),
    .out_read_value(out_read_value)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned eff_capacity(int unsigned c);
    int unsigned e;
    e = c & 32'h1F;
    if (e == 0) e = 1;
    if (e > ENTRIES) e = ENTRIES;
    return e;
  endfunction

  function automatic int find_slot(lkvc_pkg::key_t k);
    int i;
    for (i = 0; i < ENTRIES; i++)
      if (slot_live[i] && slot_key[i] == k) return i;
    return -1;
  endfunction

  function automatic void touch_slot(int s);
    int i;
    for (i = 0; i < ENTRIES; i++)
      if (slot_live[i] && i != s && slot_age[i] < slot_age[s]) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  function automatic void cache_apply(request_t r);
    int      s;
    int      i;
    int      oldest;
    int      free_slot;
    lookup_t res;
    s = find_slot(r.key);
    if (r.op == lkvc_pkg::OP_GET) begin
      res.found = (s >= 0);
      res.val   = (s >= 0) ? slot_val[s] : '0;
      if (s >= 0) touch_slot(s);
      lookups_due.push_back(res);
    end else if (s >= 0) begin
      slot_val[s] = r.val;
      touch_slot(s);
    end else begin
      if (live_count >= eff_capacity(cap_setting)) begin
        oldest = -1;
        for (i = 0; i < ENTRIES; i++)
          if (slot_live[i] && (oldest < 0 || slot_age[i] > slot_age[oldest])) oldest = i;
        if (oldest >= 0) begin
          slot_live[oldest] = 1'b0;
          slot_age[oldest]  = 0;
          live_count--;
        end
      end
      free_slot = -1;
      for (i = 0; i < ENTRIES; i++)
        if (!slot_live[i] && free_slot < 0) free_slot = i;
      if (free_slot >= 0) begin
        for (i = 0; i < ENTRIES; i++)
          if (slot_live[i]) slot_age[i]++;
        slot_live[free_slot] = 1'b1;
        slot_key[free_slot]  = r.key;
        slot_val[free_slot]  = r.val;
        slot_age[free_slot]  = 0;
        live_count++;
      end
    end
  endfunction

  // random word, now and then one of the extremes
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  task automatic queue_req(lkvc_pkg::op_t op, lkvc_pkg::key_t k, lkvc_pkg::value_t v);
    request_t r;
    r.op  = op;
    r.key = k;
    r.val = v;
    req_q.push_back(r);
    n_queued++;
  endtask

  task automatic drain_and_settle();
    while (n_taken != n_queued || lookups_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_capacity(int unsigned c);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= c[lkvc_pkg::CAP_W-1:0];
    cap_setting = c & 32'h1F;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        cache_apply(on_bus);
        n_taken++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (req_q.size() != 0) begin
          on_bus = req_q.pop_front();
          in_valid       <= 1'b1;
          in_operation   <= on_bus.op;
          in_lookup_key  <= on_bus.key;
          in_store_value <= on_bus.val;
          gap_left       <= send_calm ? 0 : $urandom_range(0, 14);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (lookups_due.size() == 0) begin
          n_bad++;
          if (n_bad <= MAX_REPORTS)
            $display("unexpected result transfer: found=%0b value=%0d",
                     out_found, out_read_value);
        end else begin
          want = lookups_due.pop_front();
          if (out_found !== want.found || out_read_value !== want.val) begin
            n_bad++;
            if (n_bad <= MAX_REPORTS)
              $display("lookup mismatch: expected found=%0b value=%0d, got found=%0b value=%0d",
                       want.found, want.val, out_found, out_read_value);
          end
        end
        // one long hold-off so that the cache backs up and stalls its input
        if (phase_no == PRESS_PHASE && !held) begin
          stall_left = HOLD_CYCLES;
          held       = 1'b1;
        end else begin
          stall_left = recv_calm ? 0 : $urandom_range(0, 14);
        end
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // watchdog on cycles with no transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    lkvc_pkg::key_t pool [32];
    int unsigned    pool_n;
    int             p;
    int             j;
    request_t       r;
    for (j = 0; j < ENTRIES; j++) begin
      slot_live[j] = 1'b0;
      slot_age[j]  = 0;
      slot_key[j]  = '0;
      slot_val[j]  = '0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // extremes, update of a present key, miss on an empty cache
    queue_req(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
    queue_req(lkvc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_req(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'hFFFF_FFFF);
    queue_req(lkvc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_3039);
    queue_req(lkvc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_GET, 32'h0000_0005, 32'hFFFF_FFFF);
    drain_and_settle();

    // capacity zero, also below the number of entries held
    write_capacity(0);
    queue_req(lkvc_pkg::OP_PUT, 32'h0000_0007, 32'h0000_0046);
    queue_req(lkvc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_PUT, 32'h0000_0007, 32'h0000_0047);
    queue_req(lkvc_pkg::OP_GET, 32'h0000_0007, 32'h0000_0000);
    queue_req(lkvc_pkg::OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);
    drain_and_settle();

    for (p = 0; p < N_PHASES; p++) begin
      write_capacity(CAP_PLAN[p]);
      phase_no  = p;
      send_calm = (p == 2 || p == PRESS_PHASE);
      recv_calm = (p == 2 || p == 7);
      // small key pool so that gets mostly hit and puts mostly update or evict
      pool_n = eff_capacity(CAP_PLAN[p]) + $urandom_range(1, 6);
      for (j = 0; j < pool_n; j++) pool[j] = pick_word();
      for (j = 0; j < PHASE_ITEMS; j++) begin
        r.op  = lkvc_pkg::op_t'($urandom_range(0, 1));
        r.key = ($urandom_range(0, 9) == 0) ? lkvc_pkg::key_t'(pick_word())
                                            : pool[$urandom_range(0, pool_n - 1)];
        r.val = pick_word();
        queue_req(r.op, r.key, r.val);
      end
      drain_and_settle();
    end

    if (n_bad == 0 && lookups_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
